[rtl/hsvrgb_pkg.sv]
// Package for the HSV to RGB pixel converter: pixel and job types, sector
// constants and component selection codes. No dependencies.

package hsvrgb_pkg;

    localparam int HUE_W = 15;
    localparam int Q12_W = 13;
    localparam int CHAN_W = 8;
    localparam int WEIGHT_W = 10;

    // Q0.12 unity and hue constants in 1/16 degree units.
    localparam logic [Q12_W-1:0] ONE_Q12 = 13'd4096;
    localparam logic signed [HUE_W:0] FULL_TURN = 16'sd5760;
    localparam logic [12:0] SIXTY_DEG = 13'd960;

    // Source of one color channel before the offset is added.
    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_CHROMA,
        SEL_SECOND
    } comp_sel_t;

    typedef struct packed {
        logic signed [HUE_W-1:0] hue;
        logic [Q12_W-1:0] saturation;
        logic [Q12_W-1:0] brightness;
    } pixel_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_out_t;

    // Classified pixel handed from the front end to the arithmetic pipeline.
    typedef struct packed {
        logic [Q12_W-1:0] saturation;
        logic [Q12_W-1:0] brightness;
        logic [WEIGHT_W-1:0] weight;
        comp_sel_t sel_red;
        comp_sel_t sel_green;
        comp_sel_t sel_blue;
    } job_t;

endpackage

[rtl/hsvrgb_front.sv]
// Front end of the HSV to RGB converter: wraps the hue, clamps saturation and
// value, and picks the sector and secondary weight. Depends on hsvrgb_pkg.

module hsvrgb_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  hsv_valid,
    output logic                  hsv_ready,
    input  hsvrgb_pkg::pixel_in_t hsv,
    output logic                  job_valid,
    input  logic                  job_ready,
    output hsvrgb_pkg::job_t      job
);

    typedef enum logic [2:0] {
        SECT_0,
        SECT_1,
        SECT_2,
        SECT_3,
        SECT_4,
        SECT_5
    } sector_t;

    logic signed [hsvrgb_pkg::HUE_W:0] hue_ext;
    logic signed [hsvrgb_pkg::HUE_W:0] hue_pos;
    logic signed [hsvrgb_pkg::HUE_W:0] hue_wrap;
    logic                              in_range;
    logic [12:0]                       hue_deg;
    logic [12:0]                       hue_mod;
    logic [12:0]                       hue_gap;
    logic [12:0]                       weight_full;
    sector_t                           sector;
    logic [hsvrgb_pkg::Q12_W-1:0]      sat_clamp;
    logic [hsvrgb_pkg::Q12_W-1:0]      val_clamp;
    hsvrgb_pkg::job_t                  job_next;
    hsvrgb_pkg::job_t                  job_reg;
    logic                              valid_reg;

    always_comb
    begin
        hue_ext = {hsv.hue[hsvrgb_pkg::HUE_W-1], hsv.hue};
        hue_pos = (hue_ext < 0) ? hue_ext + hsvrgb_pkg::FULL_TURN : hue_ext;
        hue_wrap = (hue_pos >= hsvrgb_pkg::FULL_TURN) ? hue_pos - hsvrgb_pkg::FULL_TURN
                                                      : hue_pos;
        // A single wrap does not reach every code; such hues keep no sector.
        in_range = (hue_wrap >= 0) && (hue_wrap < hsvrgb_pkg::FULL_TURN);
        hue_deg = hue_wrap[12:0];

        priority if (hue_deg >= 13'd4800)
            sector = SECT_5;
        else if (hue_deg >= 13'd3840)
            sector = SECT_4;
        else if (hue_deg >= 13'd2880)
            sector = SECT_3;
        else if (hue_deg >= 13'd1920)
            sector = SECT_2;
        else if (hue_deg >= hsvrgb_pkg::SIXTY_DEG)
            sector = SECT_1;
        else
            sector = SECT_0;

        priority if (hue_deg >= 13'd3840)
            hue_mod = hue_deg - 13'd3840;
        else if (hue_deg >= 13'd1920)
            hue_mod = hue_deg - 13'd1920;
        else
            hue_mod = hue_deg;

        hue_gap = (hue_mod >= hsvrgb_pkg::SIXTY_DEG) ? hue_mod - hsvrgb_pkg::SIXTY_DEG
                                                     : hsvrgb_pkg::SIXTY_DEG - hue_mod;
        weight_full = hsvrgb_pkg::SIXTY_DEG - hue_gap;

        sat_clamp = (hsv.saturation > hsvrgb_pkg::ONE_Q12) ? hsvrgb_pkg::ONE_Q12
                                                           : hsv.saturation;
        val_clamp = (hsv.brightness > hsvrgb_pkg::ONE_Q12) ? hsvrgb_pkg::ONE_Q12
                                                           : hsv.brightness;

        job_next.saturation = sat_clamp;
        job_next.brightness = val_clamp;
        job_next.weight = in_range ? weight_full[hsvrgb_pkg::WEIGHT_W-1:0] : '0;
        job_next.sel_red = hsvrgb_pkg::SEL_ZERO;
        job_next.sel_green = hsvrgb_pkg::SEL_ZERO;
        job_next.sel_blue = hsvrgb_pkg::SEL_ZERO;
        if (in_range)
        begin
            unique case (sector)
                SECT_0:
                begin
                    job_next.sel_red = hsvrgb_pkg::SEL_CHROMA;
                    job_next.sel_green = hsvrgb_pkg::SEL_SECOND;
                end
                SECT_1:
                begin
                    job_next.sel_red = hsvrgb_pkg::SEL_SECOND;
                    job_next.sel_green = hsvrgb_pkg::SEL_CHROMA;
                end
                SECT_2:
                begin
                    job_next.sel_green = hsvrgb_pkg::SEL_CHROMA;
                    job_next.sel_blue = hsvrgb_pkg::SEL_SECOND;
                end
                SECT_3:
                begin
                    job_next.sel_green = hsvrgb_pkg::SEL_SECOND;
                    job_next.sel_blue = hsvrgb_pkg::SEL_CHROMA;
                end
                SECT_4:
                begin
                    job_next.sel_red = hsvrgb_pkg::SEL_SECOND;
                    job_next.sel_blue = hsvrgb_pkg::SEL_CHROMA;
                end
                default:
                begin
                    job_next.sel_red = hsvrgb_pkg::SEL_CHROMA;
                    job_next.sel_blue = hsvrgb_pkg::SEL_SECOND;
                end
            endcase
        end
    end

    assign hsv_ready = !valid_reg || job_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (hsv_ready)
            valid_reg <= hsv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (hsv_ready && hsv_valid)
            job_reg <= job_next;
    end

    assign job_valid = valid_reg;
    assign job = job_reg;

    // The secondary weight never exceeds sixty degrees.
    a_weight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (job_reg.weight <= hsvrgb_pkg::SIXTY_DEG[hsvrgb_pkg::WEIGHT_W-1:0]))
        else $error("secondary weight above sixty degrees");

endmodule

[rtl/hsvrgb_queue.sv]
// Small FIFO that decouples the HSV front end from the arithmetic pipeline.
// Depends on hsvrgb_pkg for the job type.

module hsvrgb_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  hsvrgb_pkg::job_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output hsvrgb_pkg::job_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    hsvrgb_pkg::job_t [DEPTH-1:0] slot_reg;
    logic [PTR_W-1:0]             wr_ptr_reg;
    logic [PTR_W-1:0]             rd_ptr_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         push;
    logic                         pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign push = push_valid && push_ready;
    assign pop = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    // An empty or full queue must have equal read and write pointers.
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == FULL_CNT) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with fill level");

endmodule

[rtl/hsvrgb_back.sv]
// Arithmetic pipeline of the HSV to RGB converter: chroma, component sums,
// scaling by 255 and exact division by 15 * 2^30. Depends on hsvrgb_pkg.

module hsvrgb_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   job_valid,
    output logic                   job_ready,
    input  hsvrgb_pkg::job_t       job,
    output logic                   rgb_valid,
    input  logic                   rgb_ready,
    output hsvrgb_pkg::pixel_out_t rgb
);

    localparam int C_W = 25;
    localparam int N_W = 34;
    localparam int Y_W = 12;
    localparam logic [15:0] RECIP_15 = 16'd34953;
    localparam logic [Y_W-1:0] Y_MAX = 12'd3825;

    typedef struct packed {
        hsvrgb_pkg::comp_sel_t sel_red;
        hsvrgb_pkg::comp_sel_t sel_green;
        hsvrgb_pkg::comp_sel_t sel_blue;
    } sel_set_t;

    // Stage valids and ready chain.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic r1, r2, r3, r4, r5;

    // Stage 1: chroma.
    logic [C_W-1:0]                  c_next;
    logic [C_W-1:0]                  c1_reg;
    logic [hsvrgb_pkg::Q12_W-1:0]    v1_val_reg;
    logic [hsvrgb_pkg::WEIGHT_W-1:0] w1_reg;
    sel_set_t                        sel1_reg;

    // Stage 2: secondary, chroma and offset numerators.
    logic [N_W-1:0] px_next;
    logic [N_W-1:0] pc_next;
    logic [C_W-1:0] off_q24;
    logic [N_W-1:0] mf_next;
    logic [N_W-1:0] px2_reg;
    logic [N_W-1:0] pc2_reg;
    logic [N_W-1:0] mf2_reg;
    sel_set_t       sel2_reg;

    // Stage 3: per channel numerator, stage 4: scaled, stage 5: result.
    hsvrgb_pkg::comp_sel_t [2:0] sel2_arr;
    logic [2:0][N_W-1:0]         n_next;
    logic [2:0][N_W-1:0]         n3_reg;
    logic [2:0][N_W+7:0]         n255;
    logic [2:0][Y_W-1:0]         y_next;
    logic [2:0][Y_W-1:0]         y4_reg;
    logic [2:0][27:0]            q_prod;
    logic [2:0][7:0]             ch_next;
    logic [2:0][7:0]             ch5_reg;

    assign r5 = !v5_reg || rgb_ready;
    assign r4 = !v4_reg || r5;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign job_ready = r1;

    always_comb
    begin
        c_next = C_W'(job.saturation * job.brightness);

        px_next = N_W'(c1_reg * w1_reg);
        pc_next = N_W'({c1_reg, 10'b0}) - N_W'({c1_reg, 6'b0});
        off_q24 = {v1_val_reg[12:0], 12'b0} - c1_reg;
        mf_next = N_W'({off_q24, 10'b0}) - N_W'({off_q24, 6'b0});

        sel2_arr[0] = sel2_reg.sel_red;
        sel2_arr[1] = sel2_reg.sel_green;
        sel2_arr[2] = sel2_reg.sel_blue;
        for (int ch = 0; ch < 3; ch++)
        begin
            unique case (sel2_arr[ch])
                hsvrgb_pkg::SEL_CHROMA: n_next[ch] = pc2_reg + mf2_reg;
                hsvrgb_pkg::SEL_SECOND: n_next[ch] = px2_reg + mf2_reg;
                default:                n_next[ch] = mf2_reg;
            endcase
            // Times 255, then drop 2^30 of the 15 * 2^30 denominator.
            n255[ch] = {n3_reg[ch], 8'b0} - {8'b0, n3_reg[ch]};
            y_next[ch] = n255[ch][N_W+7:30];
            // Exact division by 15 for values below 4993.
            q_prod[ch] = 28'(y4_reg[ch] * RECIP_15);
            ch_next[ch] = q_prod[ch][26:19];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= job_valid;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
            if (r4)
                v4_reg <= v3_reg;
            if (r5)
                v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && job_valid)
        begin
            c1_reg <= c_next;
            v1_val_reg <= job.brightness;
            w1_reg <= job.weight;
            sel1_reg <= '{job.sel_red, job.sel_green, job.sel_blue};
        end
        if (r2 && v1_reg)
        begin
            px2_reg <= px_next;
            pc2_reg <= pc_next;
            mf2_reg <= mf_next;
            sel2_reg <= sel1_reg;
        end
        if (r3 && v2_reg)
            n3_reg <= n_next;
        if (r4 && v3_reg)
            y4_reg <= y_next;
        if (r5 && v4_reg)
            ch5_reg <= ch_next;
    end

    assign rgb_valid = v5_reg;
    assign rgb.red = ch5_reg[0];
    assign rgb.green = ch5_reg[1];
    assign rgb.blue = ch5_reg[2];

    // Chroma is a product of two clamped Q0.12 values, so at most 1.0 in Q0.24.
    a_chroma_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (c1_reg <= C_W'(1 << 24)))
        else $error("chroma above unity");

    // The reciprocal step is exact only while the scaled value stays in range.
    a_scaled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (y4_reg[0] <= Y_MAX && y4_reg[1] <= Y_MAX && y4_reg[2] <= Y_MAX))
        else $error("scaled channel beyond full scale");

endmodule

[rtl/hsv_to_rgb_pixel_convert.sv]
// Top level of the HSV to RGB pixel converter: front end, decoupling queue
// and arithmetic pipeline. Depends on hsvrgb_pkg and the three submodules.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   hsv     | in        | hsv_valid / hsv_ready   | hue, saturation, brightness
//   rgb     | out       | rgb_valid / rgb_ready   | red, green, blue
//
// One pixel per clock sustained while rgb_ready stays high and QUEUE_DEPTH is
// at least two. A transaction passes the front register, a queue slot and
// five arithmetic stages (chroma, numerators, per channel numerator, scaled,
// result) before it appears on the output.
// Reset empties every stage and the queue; no clearing pass is needed.
// A stalled output fills the pipeline first, then the queue, then the front.

module hsv_to_rgb_pixel_convert #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   hsv_valid,
    output logic                   hsv_ready,
    input  hsvrgb_pkg::pixel_in_t  hsv,
    output logic                   rgb_valid,
    input  logic                   rgb_ready,
    output hsvrgb_pkg::pixel_out_t rgb
);

    logic             front_valid;
    logic             front_ready;
    hsvrgb_pkg::job_t front_job;
    logic             queue_valid;
    logic             queue_ready;
    hsvrgb_pkg::job_t queue_job;

    hsvrgb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv_valid (hsv_valid),
        .hsv_ready (hsv_ready),
        .hsv       (hsv),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    hsvrgb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_job),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_job)
    );

    hsvrgb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_valid),
        .job_ready (queue_ready),
        .job       (queue_job),
        .rgb_valid (rgb_valid),
        .rgb_ready (rgb_ready),
        .rgb       (rgb)
    );

endmodule
